>>> rtl/fnis_pkg.sv
// ----------------------------------------------------------------------------
// fnis_pkg
// Shared types, constants and helpers for the four-neighbour in-place
// smoothing filter.
// ----------------------------------------------------------------------------
package fnis_pkg;

  localparam int CFG_W        = 11;
  localparam int CFG_IDX_W    = 1;
  localparam int ROW_W        = 10;
  localparam int OUT_COL_W    = 10;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int PIX_W        = 32;
  localparam int SUM_W        = 10;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 56;
  localparam int OUT_PAD_W    = OUT_DATA_W - PIX_W - OUT_COL_W - ROW_W;

  // x / 3 == (x * 683) >> 11 for every x below 2048
  localparam int DIV3_MUL     = 683;
  localparam int DIV3_SHIFT   = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef struct packed {
    logic       has_left;
    logic       has_right;
    logic       has_up;
    logic       has_down;
    logic       down_from_a;
    logic       up_fwd;
    logic       last;
    logic [2:0] cnt;
  } s1_ctrl_t;

  // truncated mean of one channel over cnt neighbours (cnt of 1 to 4)
  function automatic logic [7:0] div_count(input logic [SUM_W-1:0] sum,
                                           input logic [2:0] cnt);
    logic [SUM_W+DIV3_SHIFT-1:0] prod;
    logic [7:0]                  q;
    prod = (SUM_W+DIV3_SHIFT)'(sum) * (SUM_W+DIV3_SHIFT)'(DIV3_MUL);
    unique case (cnt)
      3'd1:    q = sum[7:0];
      3'd2:    q = sum[8:1];
      3'd3:    q = prod[DIV3_SHIFT +: 8];
      3'd4:    q = sum[9:2];
      default: q = 8'd0;
    endcase
    return q;
  endfunction

endpackage

>>> rtl/four_neighbour_inplace_smoothing_top.sv
// ----------------------------------------------------------------------------
// four_neighbour_inplace_smoothing_top
// Flow: a transaction that pushes out a pixel passes through the stage 1
//   registers into the output register once it is free; pixels leave
//   frame_width+1 input pixels behind, flush transactions drain the tail.
// Throughput: one transaction per cycle unless the output stalls; two read
//   ports on original line memory, one on smoothed, so no item waits on a port.
// Reset: control state, positions and left pixel cleared; the line memories
//   are not cleared. Width returns to min(MAX_WIDTH, 100), height to 100.
// ----------------------------------------------------------------------------
module four_neighbour_inplace_smoothing_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  // cfg
  input  logic                             cfg_wr_en,
  input  logic [fnis_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fnis_pkg::CFG_W-1:0]       cfg_data,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // blue_in[7:0], green_in[15:8], red_in[23:16], alpha_in[31:24]
  input  logic [fnis_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // func[0]
  input  logic                             s_axis_tuser,
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // blue_out[7:0], green_out[15:8], red_out[23:16], alpha_out[31:24],
  // out_column[41:32], out_row[51:42], zero pad[55:52]
  output logic [fnis_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // frame_end
  output logic                             m_axis_tlast
);
  import fnis_pkg::*;

  localparam int SLOT_W      = $clog2(MAX_WIDTH + 1);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int CNT_W       = $clog2(MAX_WIDTH + 2);
  localparam int DEPTH       = MAX_WIDTH + 1;
  localparam int RESET_WIDTH = (MAX_WIDTH < 100) ? MAX_WIDTH : 100;
  localparam int RESET_HEIGHT = 100;

  // config and stream position
  logic [CNT_W-1:0]  width_r;
  logic [CFG_W-1:0]  height_r;
  logic [CNT_W-1:0]  width_cfg;
  logic [CFG_W-1:0]  height_cfg;
  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W-1:0] old_slot;
  logic [CNT_W-1:0]  pending;
  logic [COL_W-1:0]  emit_column;
  logic [ROW_W-1:0]  emit_row;

  // stage 0
  logic              s_fire;
  logic              is_pixel;
  logic              ring_full;
  logic              emit0;
  logic              x_last;
  logic              y_last;
  logic [SLOT_W-1:0] addr_a;
  logic [SLOT_W-1:0] addr_b;
  logic [SLOT_W-1:0] wr_slot_inc;
  logic [SLOT_W-1:0] old_slot_inc;
  s1_ctrl_t          ctrl0;

  // stage 1
  logic              s1_valid;
  s1_ctrl_t          s1;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_row;
  logic [PIX_W-1:0]  rd_a;
  logic [PIX_W-1:0]  rd_b;
  logic [PIX_W-1:0]  rd_up;
  logic [PIX_W-1:0]  left_smoothed;
  logic [PIX_W-1:0]  up_pix;
  logic [PIX_W-1:0]  down_pix;
  logic [PIX_W-1:0]  result;
  logic [SUM_W-1:0]  ch_sum [4];
  logic [7:0]        ch_q [4];
  logic              out_load;

  // output register
  logic              out_valid;
  logic [PIX_W-1:0]  out_pix;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_row;
  logic              out_last;

  logic [PIX_W-1:0]  orig_mem   [DEPTH];
  logic [PIX_W-1:0]  smooth_mem [MAX_WIDTH];

  // config clamping
  always_comb begin
    if (cfg_data == '0) begin
      width_cfg  = CNT_W'(1);
      height_cfg = CFG_W'(1);
    end else begin
      width_cfg  = (int'(cfg_data) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : CNT_W'(cfg_data);
      height_cfg = (int'(cfg_data) > HEIGHT_LIMIT) ? CFG_W'(HEIGHT_LIMIT) : cfg_data;
    end
  end

  // stage 0 decode
  assign s_fire       = s_axis_tvalid && s_axis_tready;
  assign is_pixel     = (s_axis_tuser == FUNC_PIXEL);
  assign ring_full    = (pending == width_r + CNT_W'(1));
  assign emit0        = is_pixel ? ring_full : (pending != '0);
  assign x_last       = (CNT_W'(emit_column) + CNT_W'(1) == width_r);
  assign y_last       = (CFG_W'(emit_row) + CFG_W'(1) == height_r);
  assign wr_slot_inc  = (CNT_W'(wr_slot) == width_r) ? '0 : wr_slot + SLOT_W'(1);
  assign old_slot_inc = (CNT_W'(old_slot) == width_r) ? '0 : old_slot + SLOT_W'(1);
  assign addr_a       = old_slot_inc;

  always_comb begin
    if (width_r == CNT_W'(1)) begin
      addr_b = old_slot;
    end else if (old_slot == '0) begin
      addr_b = SLOT_W'(width_r);
    end else begin
      addr_b = old_slot - SLOT_W'(1);
    end
  end

  always_comb begin
    ctrl0.has_left    = (emit_column != '0);
    ctrl0.has_right   = !x_last;
    ctrl0.has_up      = (emit_row != '0);
    ctrl0.has_down    = !y_last;
    ctrl0.down_from_a = (width_r == CNT_W'(1));
    ctrl0.up_fwd      = out_load && (s1_col == emit_column);
    ctrl0.last        = x_last && y_last;
    ctrl0.cnt         = 3'(ctrl0.has_left) + 3'(ctrl0.has_right)
                      + 3'(ctrl0.has_up) + 3'(ctrl0.has_down);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_r       <= CNT_W'(RESET_WIDTH);
      height_r      <= CFG_W'(RESET_HEIGHT);
      wr_slot       <= '0;
      old_slot      <= '0;
      pending       <= '0;
      emit_column   <= '0;
      emit_row      <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  width_r  <= width_cfg;
        CFG_FRAME_HEIGHT: height_r <= height_cfg;
        default: ;
      endcase
      wr_slot     <= '0;
      old_slot    <= '0;
      pending     <= '0;
      emit_column <= '0;
      emit_row    <= '0;
    end else if (s_fire) begin
      if (is_pixel) begin
        wr_slot <= wr_slot_inc;
        if (!ring_full) begin
          pending <= pending + CNT_W'(1);
        end
      end else if (pending != '0) begin
        pending <= pending - CNT_W'(1);
      end
      if (emit0) begin
        old_slot <= old_slot_inc;
        if (x_last) begin
          emit_column <= '0;
          emit_row    <= y_last ? '0 : emit_row + ROW_W'(1);
        end else begin
          emit_column <= emit_column + COL_W'(1);
        end
      end
    end
  end

  // original line memory: one write, two reads
  always_ff @(posedge clk) begin
    if (s_fire && is_pixel) begin
      orig_mem[wr_slot] <= s_axis_tdata;
    end
    if (s_fire) begin
      rd_a <= orig_mem[addr_a];
      rd_b <= orig_mem[addr_b];
    end
  end

  // smoothed line memory: one write, one read
  always_ff @(posedge clk) begin
    if (out_load) begin
      smooth_mem[s1_col] <= result;
    end
    if (s_fire) begin
      rd_up <= smooth_mem[emit_column];
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_fire) begin
      s1_valid <= emit0;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1     <= ctrl0;
      s1_col <= emit_column;
      s1_row <= emit_row;
    end
  end

  // stage 1 averaging
  assign up_pix   = s1.up_fwd ? left_smoothed : rd_up;
  assign down_pix = s1.down_from_a ? rd_a : rd_b;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      ch_sum[c] = (s1.has_left  ? SUM_W'(left_smoothed[8*c +: 8]) : '0)
                + (s1.has_right ? SUM_W'(rd_a[8*c +: 8])          : '0)
                + (s1.has_up    ? SUM_W'(up_pix[8*c +: 8])        : '0)
                + (s1.has_down  ? SUM_W'(down_pix[8*c +: 8])      : '0);
      ch_q[c]   = div_count(ch_sum[c], s1.cnt);
    end
    // lone pixel in a 1x1 frame passes through
    if (s1.cnt == 3'd0) begin
      result = rd_b;
    end else begin
      result = {ch_q[3], ch_q[2], ch_q[1], ch_q[0]};
    end
  end

  assign out_load      = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_smoothed <= '0;
    end else if (cfg_wr_en) begin
      left_smoothed <= '0;
    end else if (out_load) begin
      left_smoothed <= result;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix  <= result;
      out_col  <= s1_col;
      out_row  <= s1_row;
      out_last <= s1.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {OUT_PAD_W'(0), out_row, OUT_COL_W'(out_col), out_pix};

  // checks
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= width_r + CNT_W'(1))
    else $error("pending count beyond ring size");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (CNT_W'(wr_slot) <= width_r) && (CNT_W'(old_slot) <= width_r))
    else $error("ring slot out of range");

  a_empty_flush: assert property (@(posedge clk) disable iff (rst)
    s_fire && (s_axis_tuser == FUNC_FLUSH) && (pending == '0) |=> !s1_valid)
    else $error("flush with nothing pending produced a pixel");

  a_last_column: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> (CNT_W'(out_col) + CNT_W'(1) == width_r))
    else $error("frame end away from last column");

endmodule
